// ----- src/draw_order_key_sorter_assert.svh -----
// ----------------------------------------------------------------------------
// draw_order_key_sorter_assert.svh
// Assertion macros of the draw order key sorter checker.
// ----------------------------------------------------------------------------
`ifndef DRAW_ORDER_KEY_SORTER_ASSERT_SVH
`define DRAW_ORDER_KEY_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dok_pkg.sv -----
// ----------------------------------------------------------------------------
// dok_pkg
// Shared constants and types of the draw order key sorter.
// ----------------------------------------------------------------------------
package dok_pkg;

  // Default sizes
  localparam int unsigned MAX_DRAWS_DEF  = 64;
  localparam int unsigned DEPTH_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // Fixed port widths
  localparam int unsigned ALPHA_W     = 2;
  localparam int unsigned IN_DEPTH_W  = 32;
  localparam int unsigned OUT_INDEX_W = 6;

  // Alpha mode codes
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 2'd0;
  localparam logic [ALPHA_W-1:0] ALPHA_MASK   = 2'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_BLEND  = 2'd2;

  // Per-item control flags passed from front to back
  typedef struct packed {
    logic stored;  // key was written into the store (store not full)
    logic last;    // item closes the batch
  } dok_ctrl_t;

endpackage

// ----- src/dok_ram.sv -----
// ----------------------------------------------------------------------------
// dok_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dok_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/dok_front.sv -----
// ----------------------------------------------------------------------------
// dok_front
// Input side: takes draw keys, counts the batch, marks keys past the store
// size and turns each key into one unsigned sort key.
// ----------------------------------------------------------------------------
module dok_front #(
  parameter int unsigned MAX_DRAWS  = dok_pkg::MAX_DRAWS_DEF,
  parameter int unsigned DEPTH_BITS = dok_pkg::DEPTH_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dok_pkg::ALPHA_W-1:0]         alpha_mode_i,
  input  logic                                double_sided_i,
  input  logic signed [dok_pkg::IN_DEPTH_W-1:0] view_depth_i,
  input  logic                                depth_invalid_i,
  input  logic                                last_draw_i,
  input  logic                                full_i,
  output logic                                push_o,
  output logic [DEPTH_BITS+1:0]               key_o,
  output dok_pkg::dok_ctrl_t                  ctrl_o
);

  localparam int unsigned KEY_W = DEPTH_BITS + 2;
  localparam int unsigned CNT_W = $clog2(MAX_DRAWS + 1);

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         accept;
  logic                         stored;
  logic signed [DEPTH_BITS-1:0] depth;
  logic [2:0]                   pipe_idx;
  logic                         is_blend;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign stored     = (cnt_q != CNT_W'(MAX_DRAWS));

  // Batch fill count
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_draw_i) begin
        cnt_d = '0;
      end else if (stored) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Sort key: ascending unsigned order is draw order, ties keep load order.
  // Non-blend: class 0, pipeline index. Blend: class 1, invalid flag, then
  // the depth with its sign flipped and inverted so deeper sorts first.
  assign depth    = DEPTH_BITS'(view_depth_i);
  assign pipe_idx = {alpha_mode_i, double_sided_i};
  assign is_blend = (alpha_mode_i == dok_pkg::ALPHA_BLEND);

  always_comb begin
    if (!is_blend) begin
      key_o = {1'b0, (KEY_W-1)'(pipe_idx)};
    end else if (depth_invalid_i) begin
      key_o = {2'b11, {DEPTH_BITS{1'b0}}};
    end else begin
      key_o = {2'b10, depth[DEPTH_BITS-1], ~depth[DEPTH_BITS-2:0]};
    end
  end

  assign push_o        = accept;
  assign ctrl_o.stored = stored;
  assign ctrl_o.last   = last_draw_i;

endmodule

// ----- src/dok_fifo.sv -----
// ----------------------------------------------------------------------------
// dok_fifo
// Small flip-flop queue between the front and back parts.
// ----------------------------------------------------------------------------
module dok_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dok_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = data_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/dok_back.sv -----
// ----------------------------------------------------------------------------
// dok_back
// Back part: insertion sort into the order RAM as keys arrive, then emission
// of the stored load positions in order once the batch is closed.
// ----------------------------------------------------------------------------
module dok_back #(
  parameter int unsigned MAX_DRAWS  = dok_pkg::MAX_DRAWS_DEF,
  parameter int unsigned DEPTH_BITS = dok_pkg::DEPTH_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  logic [DEPTH_BITS+1:0]            key_i,
  input  dok_pkg::dok_ctrl_t               ctrl_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dok_pkg::OUT_INDEX_W-1:0]  draw_index_o,
  output logic                             last_index_o
);

  localparam int unsigned KEY_W = DEPTH_BITS + 2;
  localparam int unsigned IDX_W = $clog2(MAX_DRAWS);
  localparam int unsigned CNT_W = $clog2(MAX_DRAWS + 1);
  localparam int unsigned ENT_W = KEY_W + IDX_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_PLACE   = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_LD = 5'b10000
  } dok_state_e;

  dok_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] emit_q, emit_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [KEY_W-1:0] new_key_q, new_key_d;
  logic [IDX_W-1:0] new_idx_q, new_idx_d;
  logic             last_q, last_d;

  logic             out_valid_q, out_valid_d;
  logic [dok_pkg::OUT_INDEX_W-1:0] draw_index_q;
  logic             last_index_q;
  logic             out_free;
  logic             out_load;
  logic             emit_is_last;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic [KEY_W-1:0] rd_key;
  logic [IDX_W-1:0] rd_idx;

  // Sorted list of {key, load position}
  dok_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_DRAWS)
  ) u_order_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_key       = rd_data[ENT_W-1 -: KEY_W];
  assign rd_idx       = rd_data[IDX_W-1:0];
  assign out_free     = ~out_valid_q | ~out_stall_i;
  assign emit_is_last = ((CNT_W'(emit_q) + CNT_W'(1)) == cnt_q);

  // Sequencer: insert walks down from the tail, one entry a cycle
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    emit_d    = emit_q;
    pos_d     = pos_q;
    new_key_d = new_key_q;
    new_idx_d = new_idx_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pos_q;
    wr_data   = {new_key_q, new_idx_q};
    rd_en     = 1'b0;
    rd_addr   = emit_q;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          new_key_d = key_i;
          new_idx_d = cnt_q[IDX_W-1:0];
          last_d    = ctrl_i.last;
          if (ctrl_i.stored) begin
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q == '0) begin
              // first key of the batch goes straight to the head
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = {key_i, IDX_W'(0)};
              state_d = ctrl_i.last ? S_EMIT_RD : S_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = IDX_W'(cnt_q - CNT_W'(1));
              pos_d   = cnt_q[IDX_W-1:0];
              state_d = S_SCAN;
            end
          end else begin
            // store full: key dropped, batch may still close
            state_d = ctrl_i.last ? S_EMIT_RD : S_IDLE;
          end
        end
      end

      S_SCAN: begin
        wr_en = 1'b1;
        if (rd_key > new_key_q) begin
          // shift the larger entry up one slot
          wr_data = rd_data;
          pos_d   = pos_q - IDX_W'(1);
          if (pos_q == IDX_W'(1)) begin
            state_d = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_q - IDX_W'(2);
          end
        end else begin
          state_d = last_q ? S_EMIT_RD : S_IDLE;
        end
      end

      S_PLACE: begin
        wr_en   = 1'b1;
        state_d = last_q ? S_EMIT_RD : S_IDLE;
      end

      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = emit_q;
        state_d = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_is_last) begin
            cnt_d   = '0;
            emit_d  = '0;
            state_d = S_IDLE;
          end else begin
            emit_d  = emit_q + IDX_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      emit_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    new_key_q <= new_key_d;
    new_idx_q <= new_idx_d;
    if (out_load) begin
      draw_index_q <= dok_pkg::OUT_INDEX_W'(rd_idx);
      last_index_q <= emit_is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign draw_index_o = draw_index_q;
  assign last_index_o = last_index_q;

endmodule

// ----- src/draw_order_key_sorter.sv -----
// ----------------------------------------------------------------------------
// draw_order_key_sorter
// Collects a batch of draw keys and emits their load positions in draw order.
// ----------------------------------------------------------------------------
// A key is taken and queued; the back end then inserts it into a sorted
// order RAM, walking down from the tail one entry per cycle. The first key
// of a batch goes straight to the head, and a dropped key is not stored.
// When the key marked last has been inserted or dropped, the batch is
// emitted one index at a time: each is read from the RAM and then loaded
// into the output register, where it is held under stall. The order RAM
// has a single read and a single write port. Keys of the next batch are
// accepted into the 4-entry queue while a batch is being emitted. Non-blend
// draws come first by pipeline index, then blend draws far to near, invalid
// depths last; equal keys keep load order.
// ----------------------------------------------------------------------------
module draw_order_key_sorter #(
  parameter int unsigned MAX_DRAWS  = dok_pkg::MAX_DRAWS_DEF,
  parameter int unsigned DEPTH_BITS = dok_pkg::DEPTH_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [dok_pkg::ALPHA_W-1:0]           alpha_mode_i,
  input  logic                                  double_sided_i,
  input  logic signed [dok_pkg::IN_DEPTH_W-1:0] view_depth_i,
  input  logic                                  depth_invalid_i,
  input  logic                                  last_draw_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [dok_pkg::OUT_INDEX_W-1:0]       draw_index_o,
  output logic                                  last_index_o
);

  localparam int unsigned KEY_W = DEPTH_BITS + 2;
  localparam int unsigned CTL_W = $bits(dok_pkg::dok_ctrl_t);
  localparam int unsigned Q_W   = KEY_W + CTL_W;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [KEY_W-1:0]   front_key;
  dok_pkg::dok_ctrl_t front_ctrl;
  logic [Q_W-1:0]     q_out;
  logic [KEY_W-1:0]   back_key;
  dok_pkg::dok_ctrl_t back_ctrl;

  // Front: accept and classify
  dok_front #(
    .MAX_DRAWS  (MAX_DRAWS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .alpha_mode_i    (alpha_mode_i),
    .double_sided_i  (double_sided_i),
    .view_depth_i    (view_depth_i),
    .depth_invalid_i (depth_invalid_i),
    .last_draw_i     (last_draw_i),
    .full_i          (full),
    .push_o          (push),
    .key_o           (front_key),
    .ctrl_o          (front_ctrl)
  );

  // Queue between front and back
  dok_fifo #(
    .WIDTH (Q_W),
    .DEPTH (dok_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({front_ctrl, front_key}),
    .pop_i       (pop),
    .pop_data_o  (q_out),
    .full_o      (full),
    .empty_o     (empty)
  );

  assign back_key  = q_out[KEY_W-1:0];
  assign back_ctrl = dok_pkg::dok_ctrl_t'(q_out[Q_W-1:KEY_W]);

  // Back: sort and emit
  dok_back #(
    .MAX_DRAWS  (MAX_DRAWS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .key_i        (back_key),
    .ctrl_i       (back_ctrl),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .draw_index_o (draw_index_o),
    .last_index_o (last_index_o)
  );

endmodule

// ----- src/dok_checker.sv -----
// ----------------------------------------------------------------------------
// dok_checker
// Port-level checks of the draw order key sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "draw_order_key_sorter_assert.svh"

module dok_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [dok_pkg::OUT_INDEX_W-1:0] draw_index_o,
  input logic                            last_index_o
);

  logic seen_q;

  // Any item taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      seen_q <= 1'b1;
    end
  end

  // Stalled result stays offered
  `DOK_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")
  // Stalled result holds its payload
  `DOK_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(draw_index_o) && $stable(last_index_o), "result changed under stall")
  // No result before any item was taken
  `DOK_ASSERT_NOW(a_no_early_out, out_valid_o, seen_q, "result without any input item")

endmodule

bind draw_order_key_sorter dok_checker u_dok_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .draw_index_o (draw_index_o),
  .last_index_o (last_index_o)
);

// ----- tb/sv/tb_draw_order_key_sorter.sv -----
// ----------------------------------------------------------------------------
// tb_draw_order_key_sorter
// Self-checking bench for the draw order key sorter.
// ----------------------------------------------------------------------------
// Batches of draw keys are fed through a valid/stall driver. A predictor keeps
// its own copy of each batch and computes the expected draw order: non-blend
// draws by pipeline index, then blend draws far to near with invalid depths
// last, with ties kept in load order. A monitor compares every emitted index
// with the oldest expected one. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_draw_order_key_sorter;

  localparam int unsigned DRAW_CAP       = dok_pkg::MAX_DRAWS_DEF;
  localparam int          RANDOM_ITEMS   = 320;
  localparam int          HOLDOFF_AT     = 40;    // result count that starts the hold-off
  localparam int          HOLDOFF_CYCLES = 300;
  localparam int          STALL_LIMIT    = 3000;  // cycles without any handshake
  localparam int          TAIL_CYCLES    = 200;

  // Alpha code that the package leaves unnamed; sorts as non-blend
  localparam logic [dok_pkg::ALPHA_W-1:0] ALPHA_SPARE = 2'd3;

  localparam logic [dok_pkg::IN_DEPTH_W-1:0] DEPTH_MAX  = 32'h7fff_ffff;
  localparam logic [dok_pkg::IN_DEPTH_W-1:0] DEPTH_MIN  = 32'h8000_0000;
  localparam logic [dok_pkg::IN_DEPTH_W-1:0] DEPTH_ZERO = 32'h0000_0000;
  localparam logic [dok_pkg::IN_DEPTH_W-1:0] DEPTH_NEG1 = 32'hffff_ffff;

  typedef struct packed {
    logic [dok_pkg::ALPHA_W-1:0]    alpha;
    logic                           dsided;
    logic [dok_pkg::IN_DEPTH_W-1:0] depth;
    logic                           invalid;
    logic                           last;
  } draw_key_t;

  typedef struct packed {
    logic [dok_pkg::OUT_INDEX_W-1:0] index;
    logic                            last;
  } draw_slot_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid  = 1'b0;
  draw_key_t cur_key   = '0;
  logic      out_stall = 1'b0;

  logic                            in_stall;
  logic                            out_valid;
  logic [dok_pkg::OUT_INDEX_W-1:0] draw_index;
  logic                            last_index;

  draw_key_t  pending_keys[$];
  draw_slot_t expected_draws[$];

  // Predictor state: keys of the batch being loaded
  draw_key_t batch_keys[DRAW_CAP];
  int        batch_len = 0;

  int  errors       = 0;
  int  results_seen = 0;
  int  gap_left     = 0;
  int  hold_left    = 0;
  int  hold_next;
  int  quiet_cycles = 0;
  bit  tx_burst     = 1'b0;
  bit  rx_burst     = 1'b0;
  bit  holdoff_done = 1'b0;

  draw_order_key_sorter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .alpha_mode_i   (cur_key.alpha),
    .double_sided_i (cur_key.dsided),
    .view_depth_i   (cur_key.depth),
    .depth_invalid_i(cur_key.invalid),
    .last_draw_i    (cur_key.last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .draw_index_o   (draw_index),
    .last_index_o   (last_index)
  );

  always #6 clk_i = ~clk_i;

  // True when draw a of the batch is emitted ahead of draw b
  function automatic bit draws_ahead(int a, int b);
    draw_key_t ka;
    draw_key_t kb;
    bit        blend_a;
    bit        blend_b;
    ka      = batch_keys[a];
    kb      = batch_keys[b];
    blend_a = (ka.alpha == dok_pkg::ALPHA_BLEND);
    blend_b = (kb.alpha == dok_pkg::ALPHA_BLEND);
    if (blend_a != blend_b) return !blend_a;
    if (!blend_a) begin
      // pipeline index is alpha * 2 + double sided
      if ({ka.alpha, ka.dsided} != {kb.alpha, kb.dsided})
        return {ka.alpha, ka.dsided} < {kb.alpha, kb.dsided};
      return a < b;
    end
    if (ka.invalid != kb.invalid) return !ka.invalid;
    if (!ka.invalid && ka.depth != kb.depth) return $signed(ka.depth) > $signed(kb.depth);
    return a < b;
  endfunction

  // Store an accepted key; on the last one, sort the batch and queue its order
  function automatic void absorb_key(draw_key_t k);
    int         order[DRAW_CAP];
    int         cur;
    int         j;
    draw_slot_t slot;
    if (batch_len < DRAW_CAP) begin
      batch_keys[batch_len] = k;
      batch_len++;
    end
    if (!k.last) return;
    for (int i = 0; i < batch_len; i++) order[i] = i;
    // stable insertion sort
    for (int i = 1; i < batch_len; i++) begin
      cur = order[i];
      j   = i;
      while (j > 0 && draws_ahead(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < batch_len; i++) begin
      slot.index = order[i][dok_pkg::OUT_INDEX_W-1:0];
      slot.last  = (i == batch_len - 1);
      expected_draws.push_back(slot);
    end
    batch_len = 0;
  endfunction

  // Idle length per item; bursts with no idling come and go
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic draw_key_t random_key(logic last);
    draw_key_t k;
    k.alpha  = ($urandom_range(0, 2) == 0) ? dok_pkg::ALPHA_BLEND
                                           : dok_pkg::ALPHA_W'($urandom_range(0, 3));
    k.dsided = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: k.depth = DEPTH_MAX;
          1: k.depth = DEPTH_MIN;
          2: k.depth = DEPTH_ZERO;
          default: k.depth = DEPTH_NEG1;
        endcase
      end
      // few distinct depths so that ties show up
      1, 2: k.depth = dok_pkg::IN_DEPTH_W'($signed($urandom_range(0, 6)) - 3) << 16;
      default: k.depth = $urandom;
    endcase
    k.invalid = ($urandom_range(0, 3) == 0);
    k.last    = last;
    return k;
  endfunction

  task automatic queue_key(logic [dok_pkg::ALPHA_W-1:0] alpha, logic dsided,
                           logic [dok_pkg::IN_DEPTH_W-1:0] depth, logic invalid,
                           logic last);
    pending_keys.push_back('{alpha, dsided, depth, invalid, last});
  endtask

  task automatic queue_batch(int count);
    for (int i = 0; i < count; i++) pending_keys.push_back(random_key(i == count - 1));
  endtask

  // Driver: offers pending keys, holds them while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) absorb_key(cur_key);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_keys.size() != 0) begin
          cur_key  <= pending_keys.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_wait(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each emitted index and draws the stall after it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      hold_next = hold_left;
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          $display("%0t: unexpected draw: expected none, got index %0d last %0d",
                   $time, draw_index, last_index);
          errors++;
        end else begin
          if (draw_index !== expected_draws[0].index || last_index !== expected_draws[0].last) begin
            $display("%0t: draw mismatch: expected index %0d last %0d, got index %0d last %0d",
                     $time, expected_draws[0].index, expected_draws[0].last,
                     draw_index, last_index);
            errors++;
          end
          void'(expected_draws.pop_front());
        end
        results_seen++;
        hold_next = draw_wait(rx_burst);
        // one long hold-off so the input queue fills and stalls
        if (!holdoff_done && results_seen == HOLDOFF_AT) begin
          hold_next    = HOLDOFF_CYCLES;
          holdoff_done = 1'b1;
        end
      end else if (hold_next > 0) begin
        hold_next--;
      end
      hold_left <= hold_next;
      out_stall <= (hold_next > 0);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[draw_order_key_sorter] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int random_items;
    int batch_no;
    int size;
    random_items = 0;
    batch_no     = 0;

    // Single-key batch
    queue_key(dok_pkg::ALPHA_OPAQUE, 1'b0, DEPTH_ZERO, 1'b0, 1'b1);
    // Every pipeline index loaded in reverse, blend depth extremes, ties, invalid depths
    queue_key(ALPHA_SPARE,           1'b1, DEPTH_ZERO, 1'b0, 1'b0);
    queue_key(ALPHA_SPARE,           1'b0, DEPTH_MAX,  1'b1, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b1, DEPTH_MIN,  1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b0, DEPTH_NEG1, 1'b1, 1'b0);
    queue_key(dok_pkg::ALPHA_MASK,   1'b1, DEPTH_MIN,  1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_MASK,   1'b0, DEPTH_ZERO, 1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b0, DEPTH_MAX,  1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_OPAQUE, 1'b1, DEPTH_NEG1, 1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b1, DEPTH_MIN,  1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b1, DEPTH_ZERO, 1'b1, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b0, DEPTH_NEG1, 1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_OPAQUE, 1'b0, DEPTH_MAX,  1'b1, 1'b0);
    queue_key(ALPHA_SPARE,           1'b1, DEPTH_MIN,  1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_OPAQUE, 1'b0, DEPTH_ZERO, 1'b0, 1'b1);
    // Blend pair with equal depths keeps load order
    queue_key(dok_pkg::ALPHA_BLEND,  1'b0, DEPTH_MAX,  1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b1, DEPTH_MAX,  1'b0, 1'b1);
    // Blend pair near to far gets swapped
    queue_key(dok_pkg::ALPHA_BLEND,  1'b0, DEPTH_NEG1, 1'b0, 1'b0);
    queue_key(dok_pkg::ALPHA_BLEND,  1'b0, DEPTH_ZERO, 1'b0, 1'b1);

    // Random batches: mostly small, one overfull (tail keys dropped), one exactly full
    while (random_items < RANDOM_ITEMS) begin
      case (batch_no)
        2:       size = DRAW_CAP + 6;
        6:       size = DRAW_CAP;
        default: size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
      endcase
      queue_batch(size);
      random_items += size;
      batch_no++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_keys.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("[draw_order_key_sorter] OK");
    end else begin
      $display("[draw_order_key_sorter] ERROR");
    end
    $finish;
  end

endmodule
